FILE: design/moore_contour_tracer_defines.svh
// ----------------------------------------------------------------------------
// Moore contour tracer assertion macros
// Shared helpers for the concurrent checks of the contour tracer.
// ----------------------------------------------------------------------------
`ifndef MOORE_CONTOUR_TRACER_DEFINES_SVH
`define MOORE_CONTOUR_TRACER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/mct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moore contour tracer package
// Transaction types, request and register codes and the neighbor tables.
// ----------------------------------------------------------------------------
package mct_pkg;

  // Request transaction.
  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] cell_x;
    logic [6:0] cell_y;
  } mct_req_t;

  // Result transaction.
  typedef struct packed {
    logic       point_valid;
    logic [6:0] point_x;
    logic [6:0] point_y;
    logic       trace_done;
  } mct_res_t;

  // Request codes.
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_MARK  = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;
  localparam logic [1:0] REQ_STEP  = 2'd3;

  // Configuration register indexes.
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Largest grid side the coordinate fields can address.
  localparam int MAX_SIDE = 128;
  localparam logic [7:0] SIDE_RESET = 8'd128;
  localparam logic [7:0] MIN_SIDE   = 8'd3;

  // Direction codes: E, SE, S, SW, W, NW, N, NE are 0..7.
  localparam logic [2:0] DIR_WEST     = 3'd4;
  localparam logic [2:0] DIR_OPPOSITE = 3'd4;

  // Column offset + 1 and row offset + 1 of every direction.
  localparam logic [1:0] DIR_COL [8] = '{2'd2, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0, 2'd1, 2'd2};
  localparam logic [1:0] DIR_ROW [8] = '{2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0};

  // Fixed results.
  localparam mct_res_t RES_EMPTY = '{point_valid: 1'b0, point_x: 7'd0,
                                     point_y: 7'd0, trace_done: 1'b0};
  localparam mct_res_t RES_DONE  = '{point_valid: 1'b0, point_x: 7'd0,
                                     point_y: 7'd0, trace_done: 1'b1};

endpackage

FILE: design/moore_contour_tracer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moore contour tracer
// Binary occupancy grid with Moore-neighbor contour tracing.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_stall/req_data: clear the grid, mark a
//   cell, start a trace or step it. Every request gives exactly one result
//   transaction on res_valid/res_stall/res_data, in request order.
//   The grid is kept one row per word in a single-port-style memory with a
//   registered read; a clear only writes rows, the other requests read rows
//   as needed before a decision or a write back, one request at a time.
//   The result reaches the output register at the same edge at which the
//   block returns to idle for the next request; the step loop runs three
//   row reads and an eight-way neighbor pick.
//   After reset a clearing pass writes ROW_N rows (one per cycle) while
//   req_stall stays high; configuration writes are taken at any time.
//   When the receiver stalls, the finished result waits in the output
//   register; the block still takes one more request and holds that one's
//   result until the register frees.
// ----------------------------------------------------------------------------
`include "moore_contour_tracer_defines.svh"

module moore_contour_tracer
  import mct_pkg::*;
#(
  parameter int GRID_COLS = 128,
  parameter int GRID_ROWS = 128
) (
  input  logic     clk,
  input  logic     rst,
  // Request channel.
  input  logic     req_valid,
  output logic     req_stall,
  input  mct_req_t req_data,
  // Result channel.
  output logic     res_valid,
  input  logic     res_stall,
  output mct_res_t res_data,
  // Configuration port.
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  // Memory geometry: only cells below the coordinate range are ever used.
  localparam int ROW_W = (GRID_COLS < MAX_SIDE) ? GRID_COLS : MAX_SIDE;
  localparam int ROW_N = (GRID_ROWS < MAX_SIDE) ? GRID_ROWS : MAX_SIDE;
  localparam int AW    = $clog2(ROW_N);

  typedef enum logic [10:0] {
    ST_CLEAR    = 11'b000_0000_0001,
    ST_IDLE     = 11'b000_0000_0010,
    ST_MARK     = 11'b000_0000_0100,
    ST_SCAN_RD  = 11'b000_0000_1000,
    ST_SCAN_CHK = 11'b000_0001_0000,
    ST_ADV_RD0  = 11'b000_0010_0000,
    ST_ADV_RD1  = 11'b000_0100_0000,
    ST_ADV_RD2  = 11'b000_1000_0000,
    ST_ADV_PICK = 11'b001_0000_0000,
    ST_EMIT     = 11'b010_0000_0000,
    ST_SPARE    = 11'b100_0000_0000
  } mct_state_t;

  // Bits at columns cx-1, cx and cx+1 of one row word.
  function automatic logic [2:0] pick3(input logic [ROW_W-1:0] row, input logic [6:0] cx);
    logic [2:0] r;
    r = '0;
    for (int i = 0; i < ROW_W; i++) begin
      if (i + 1 == int'(cx)) r[0] = row[i];
      if (i == int'(cx))     r[1] = row[i];
      if (i == int'(cx) + 1) r[2] = row[i];
    end
    return r;
  endfunction

  // Control and trace registers.
  mct_state_t  state, state_next;
  logic [AW-1:0] clr_row, clr_row_next;
  logic        clr_emit, clr_emit_next;
  logic [6:0]  scan_y, scan_y_next;
  logic [6:0]  mark_x, mark_x_next;
  logic [6:0]  mark_y, mark_y_next;
  logic [6:0]  start_x, start_x_next;
  logic [6:0]  start_y, start_y_next;
  logic [6:0]  cur_x, cur_x_next;
  logic [6:0]  cur_y, cur_y_next;
  logic [2:0]  back_dir, back_dir_next;
  logic        revisited, revisited_next;
  logic [17:0] step_count, step_count_next;
  logic        finished, finished_next;
  logic [2:0]  up_bits, up_bits_next;
  logic [2:0]  mid_bits, mid_bits_next;
  mct_res_t    pend, pend_next;
  logic        res_valid_next;
  mct_res_t    res_data_next;
  logic [7:0]  grid_width, grid_height;

  // Memory port signals.
  logic [ROW_W-1:0] grid_mem [ROW_N];
  logic             mem_re, mem_we;
  logic [AW-1:0]    mem_ra, mem_wa;
  logic [ROW_W-1:0] mem_wd, rd_data;

  // Derived values.
  logic [7:0]       eff_w, eff_h;
  logic             too_small;
  logic [15:0]      grid_area;
  logic [18:0]      step_cap;
  logic             cap_hit;
  logic [ROW_W-1:0] col_mask, scan_bits;
  logic             scan_hit;
  logic [6:0]       scan_hit_x;
  logic [6:0]       col_x [3];
  logic [6:0]       row_y [3];
  logic [2:0]       col_ok, row_ok;
  logic [2:0]       nbr_rows [3];
  logic [7:0]       nbr;
  logic             pick_found;
  logic [2:0]       pick_dir;
  logic [6:0]       pick_x, pick_y;

  assign req_stall = (state != ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= SIDE_RESET;
      grid_height <= SIDE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default:         grid_width  <= grid_width;
      endcase
    end
  end

  // Effective grid size and iteration cap.
  assign eff_w     = (grid_width  > 8'(ROW_W)) ? 8'(ROW_W) : grid_width;
  assign eff_h     = (grid_height > 8'(ROW_N)) ? 8'(ROW_N) : grid_height;
  assign too_small = (eff_w < MIN_SIDE) || (eff_h < MIN_SIDE);
  assign grid_area = {8'd0, eff_w} * {8'd0, eff_h};
  assign step_cap  = {grid_area, 3'b000};
  assign cap_hit   = ({1'b0, step_count} >= step_cap);

  // Grid memory: one row per word, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= grid_mem[mem_ra];
    end
  end

  // Row scan: lowest occupied column inside the effective width.
  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      col_mask[i] = (i < int'(eff_w));
    end
    scan_bits  = rd_data & col_mask;
    scan_hit   = |scan_bits;
    scan_hit_x = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (scan_bits[i]) scan_hit_x = 7'(i);
    end
  end

  // Neighbor coordinates and their bounds against the effective grid.
  always_comb begin
    col_x[0]  = cur_x - 7'd1;
    col_x[1]  = cur_x;
    col_x[2]  = cur_x + 7'd1;
    row_y[0]  = cur_y - 7'd1;
    row_y[1]  = cur_y;
    row_y[2]  = cur_y + 7'd1;
    col_ok[0] = (cur_x != 7'd0) && ({1'b0, cur_x} - 8'd1 < eff_w);
    col_ok[1] = ({1'b0, cur_x} < eff_w);
    col_ok[2] = ({1'b0, cur_x} + 8'd1 < eff_w);
    row_ok[0] = (cur_y != 7'd0) && ({1'b0, cur_y} - 8'd1 < eff_h);
    row_ok[1] = ({1'b0, cur_y} < eff_h);
    row_ok[2] = ({1'b0, cur_y} + 8'd1 < eff_h);
  end

  // Clockwise neighbor pick, starting one past the backtrack direction.
  always_comb begin
    logic [2:0] dir;
    nbr_rows[0] = up_bits;
    nbr_rows[1] = mid_bits;
    nbr_rows[2] = pick3(rd_data, cur_x);
    for (int d = 0; d < 8; d++) begin
      nbr[d] = nbr_rows[DIR_ROW[d]][DIR_COL[d]] & row_ok[DIR_ROW[d]] & col_ok[DIR_COL[d]];
    end
    pick_found = 1'b0;
    pick_dir   = '0;
    for (int k = 0; k < 8; k++) begin
      dir = back_dir + 3'(k + 1);
      if (!pick_found && nbr[dir]) begin
        pick_found = 1'b1;
        pick_dir   = dir;
      end
    end
    pick_x = col_x[DIR_COL[pick_dir]];
    pick_y = row_y[DIR_ROW[pick_dir]];
  end

  // Sequencer: next state, memory accesses and trace updates.
  always_comb begin
    state_next      = state;
    clr_row_next    = clr_row;
    clr_emit_next   = clr_emit;
    scan_y_next     = scan_y;
    mark_x_next     = mark_x;
    mark_y_next     = mark_y;
    start_x_next    = start_x;
    start_y_next    = start_y;
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    back_dir_next   = back_dir;
    revisited_next  = revisited;
    step_count_next = step_count;
    finished_next   = finished;
    up_bits_next    = up_bits;
    mid_bits_next   = mid_bits;
    pend_next       = pend;
    res_valid_next  = res_valid && res_stall;
    res_data_next   = res_data;
    mem_re          = 1'b0;
    mem_ra          = cur_y[AW-1:0];
    mem_we          = 1'b0;
    mem_wa          = mark_y[AW-1:0];
    mem_wd          = rd_data | ({{(ROW_W-1){1'b0}}, 1'b1} << mark_x);

    unique case (state)
      // Clearing pass: one row per cycle.
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_row;
        mem_wd = '0;
        if (clr_row == AW'(ROW_N - 1)) begin
          state_next = clr_emit ? ST_EMIT : ST_IDLE;
        end else begin
          clr_row_next = clr_row + 1'b1;
        end
      end

      // Take a request and dispatch it.
      ST_IDLE: begin
        if (req_valid) begin
          unique case (req_data.req_type)
            REQ_CLEAR: begin
              finished_next = 1'b1;
              clr_row_next  = '0;
              clr_emit_next = 1'b1;
              pend_next     = RES_EMPTY;
              state_next    = ST_CLEAR;
            end
            REQ_MARK: begin
              pend_next   = RES_EMPTY;
              mark_x_next = req_data.cell_x;
              mark_y_next = req_data.cell_y;
              if (({1'b0, req_data.cell_x} < eff_w) && ({1'b0, req_data.cell_y} < eff_h)) begin
                mem_re     = 1'b1;
                mem_ra     = req_data.cell_y[AW-1:0];
                state_next = ST_MARK;
              end else begin
                state_next = ST_EMIT;
              end
            end
            REQ_START: begin
              if (too_small) begin
                finished_next = 1'b1;
                pend_next     = RES_DONE;
                state_next    = ST_EMIT;
              end else begin
                scan_y_next = '0;
                state_next  = ST_SCAN_RD;
              end
            end
            REQ_STEP: begin
              if (finished || too_small || cap_hit) begin
                finished_next = 1'b1;
                pend_next     = RES_DONE;
                state_next    = ST_EMIT;
              end else begin
                step_count_next = step_count + 18'd1;
                state_next      = ST_ADV_RD0;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end

      // Mark: write the row back with the cell set.
      ST_MARK: begin
        mem_we     = 1'b1;
        state_next = ST_EMIT;
      end

      // Start search: read a row, then look for its first occupied cell.
      ST_SCAN_RD: begin
        mem_re     = 1'b1;
        mem_ra     = scan_y[AW-1:0];
        state_next = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        if (scan_hit) begin
          start_x_next    = scan_hit_x;
          start_y_next    = scan_y;
          cur_x_next      = scan_hit_x;
          cur_y_next      = scan_y;
          back_dir_next   = DIR_WEST;
          revisited_next  = 1'b0;
          step_count_next = '0;
          finished_next   = 1'b0;
          pend_next       = '{point_valid: 1'b1, point_x: scan_hit_x,
                              point_y: scan_y, trace_done: 1'b0};
          state_next      = ST_EMIT;
        end else if ({1'b0, scan_y} + 8'd1 >= eff_h) begin
          finished_next = 1'b1;
          pend_next     = RES_DONE;
          state_next    = ST_EMIT;
        end else begin
          scan_y_next = scan_y + 7'd1;
          state_next  = ST_SCAN_RD;
        end
      end

      // Step: read the rows above, at and below the current cell.
      ST_ADV_RD0: begin
        mem_re     = 1'b1;
        mem_ra     = row_y[0][AW-1:0];
        state_next = ST_ADV_RD1;
      end

      ST_ADV_RD1: begin
        up_bits_next = pick3(rd_data, cur_x);
        mem_re       = 1'b1;
        mem_ra       = cur_y[AW-1:0];
        state_next   = ST_ADV_RD2;
      end

      ST_ADV_RD2: begin
        mid_bits_next = pick3(rd_data, cur_x);
        mem_re        = 1'b1;
        mem_ra        = row_y[2][AW-1:0];
        state_next    = ST_ADV_PICK;
      end

      // Step: move to the first occupied neighbor.
      ST_ADV_PICK: begin
        state_next = ST_EMIT;
        if (!pick_found) begin
          finished_next = 1'b1;
          pend_next     = RES_DONE;
        end else begin
          back_dir_next = pick_dir + DIR_OPPOSITE;
          cur_x_next    = pick_x;
          cur_y_next    = pick_y;
          if ((pick_x == start_x) && (pick_y == start_y)) begin
            if (!revisited) begin
              revisited_next = 1'b1;
              pend_next      = RES_EMPTY;
            end else begin
              finished_next = 1'b1;
              pend_next     = RES_DONE;
            end
          end else begin
            pend_next = '{point_valid: 1'b1, point_x: pick_x,
                          point_y: pick_y, trace_done: 1'b0};
          end
        end
      end

      // Hand the result to the output register once it is free.
      ST_EMIT: begin
        if (!res_valid || !res_stall) begin
          res_valid_next = 1'b1;
          res_data_next  = pend;
          state_next     = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_row    <= '0;
      clr_emit   <= 1'b0;
      start_x    <= '0;
      start_y    <= '0;
      cur_x      <= '0;
      cur_y      <= '0;
      back_dir   <= DIR_WEST;
      revisited  <= 1'b0;
      step_count <= '0;
      finished   <= 1'b1;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr_row    <= clr_row_next;
      clr_emit   <= clr_emit_next;
      start_x    <= start_x_next;
      start_y    <= start_y_next;
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      back_dir   <= back_dir_next;
      revisited  <= revisited_next;
      step_count <= step_count_next;
      finished   <= finished_next;
      res_valid  <= res_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_y   <= scan_y_next;
    mark_x   <= mark_x_next;
    mark_y   <= mark_y_next;
    up_bits  <= up_bits_next;
    mid_bits <= mid_bits_next;
    pend     <= pend_next;
    res_data <= res_data_next;
  end

  // A stalled result keeps the sequencer waiting with its own result.
  `MCT_ASSERT_NEXT(a_emit_waits, (state == ST_EMIT) && res_valid && res_stall, state == ST_EMIT, "result overwrote a stalled transaction")
  // An active trace always sits inside the stored grid.
  `MCT_ASSERT_NOW(a_cur_in_grid, !finished, (int'(cur_y) < ROW_N) && (int'(cur_x) < ROW_W), "trace position outside grid memory")
  // The clearing pass ends in idle or in delivering the clear result.
  `MCT_ASSERT_NEXT(a_clear_ends, (state == ST_CLEAR) && (clr_row == AW'(ROW_N - 1)), (state == ST_IDLE) || (state == ST_EMIT), "clearing pass did not end")
  // A delivered contour point never also ends the trace.
  `MCT_ASSERT_NOW(a_point_not_done, res_valid && res_data.point_valid, !res_data.trace_done, "point transaction marked done")
  // Neighbor picks only happen on an active trace.
  `MCT_ASSERT_NOW(a_pick_active, state == ST_ADV_PICK, !finished, "step taken without an active trace")

endmodule

FILE: dv/tb_moore_contour_tracer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moore contour tracer testbench
// Drives clear, mark, start and step requests through the valid/stall
// request channel and checks every result transaction against a predictor
// that keeps its own copy of the grid, the trace state and the grid sizes.
// Directed sequences cover empty grids, isolated cells, traces along the
// grid border, both returns to the start cell, the iteration cap and
// out-of-range sizes. Random phases then trace random blobs under many size
// settings, with random idling on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_moore_contour_tracer;
  import mct_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int IDLE_PCT = 19;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 300;
  localparam int N_PHASES = 14;

  // Neighbor offsets, clockwise from east.
  localparam int STEP_DX [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
  localparam int STEP_DY [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  mct_req_t   req_data = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  mct_res_t   res_data;
  logic       cfg_write = 1'b0;
  logic       cfg_index = REG_GRID_WIDTH;
  logic [7:0] cfg_data = '0;

  moore_contour_tracer i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Stimulus and expectation stores.
  mct_req_t pending_reqs [$];
  mct_res_t expected_points [$];
  int n_queued = 0;
  int n_accepted = 0;
  int n_points = 0;
  int n_ends = 0;
  int n_settings = 0;
  int error_count = 0;
  logic req_fire = 1'b0;
  logic quiet_mode = 1'b0;
  int burst_requests = 0;
  int burst_served = 0;
  int burst_left = 0;

  // Shadow of the tracer: grid sizes, occupancy rows and trace state.
  logic [7:0] grid_w_cfg = SIDE_RESET;
  logic [7:0] grid_h_cfg = SIDE_RESET;
  logic [MAX_SIDE-1:0] occ_rows [MAX_SIDE] = '{default: '0};
  int start_x = 0;
  int start_y = 0;
  int cur_x = 0;
  int cur_y = 0;
  logic [2:0] back_dir = DIR_WEST;
  logic start_seen = 1'b0;
  int trace_steps = 0;
  logic trace_idle = 1'b1;

  function automatic int side_of(input logic [7:0] v);
    return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
  endfunction

  // Updates the shadow for one accepted request and returns its result.
  function automatic mct_res_t next_contour_result(input mct_req_t rq);
    mct_res_t res;
    int w, h, nx, ny;
    logic [2:0] dir;
    logic hit;
    res = RES_EMPTY;
    w = side_of(grid_w_cfg);
    h = side_of(grid_h_cfg);
    hit = 1'b0;
    case (rq.req_type)
      REQ_CLEAR: begin
        foreach (occ_rows[r]) occ_rows[r] = '0;
        trace_idle = 1'b1;
      end
      REQ_MARK: begin
        if (rq.cell_x < w && rq.cell_y < h) occ_rows[rq.cell_y][rq.cell_x] = 1'b1;
      end
      REQ_START: begin
        res = RES_DONE;
        if (w >= MIN_SIDE && h >= MIN_SIDE) begin
          for (int y = 0; y < h && !hit; y++) begin
            for (int x = 0; x < w && !hit; x++) begin
              if (occ_rows[y][x]) begin
                hit = 1'b1;
                start_x = x;
                start_y = y;
                cur_x = x;
                cur_y = y;
                back_dir = DIR_WEST;
                start_seen = 1'b0;
                trace_steps = 0;
                res.point_valid = 1'b1;
                res.point_x = 7'(x);
                res.point_y = 7'(y);
                res.trace_done = 1'b0;
              end
            end
          end
        end
        trace_idle = res.trace_done;
      end
      default: begin
        res = RES_DONE;
        if (!trace_idle && w >= MIN_SIDE && h >= MIN_SIDE && trace_steps < w * h * 8) begin
          trace_steps++;
          for (int k = 0; k < 8 && !hit; k++) begin
            dir = back_dir + 3'd1 + 3'(k);
            nx = cur_x + STEP_DX[dir];
            ny = cur_y + STEP_DY[dir];
            if (nx >= 0 && ny >= 0 && nx < w && ny < h && occ_rows[ny][nx]) begin
              hit = 1'b1;
              back_dir = dir + DIR_OPPOSITE;
              cur_x = nx;
              cur_y = ny;
              if (nx == start_x && ny == start_y) begin
                // The first return is silent; the second one closes the trace.
                if (!start_seen) begin
                  start_seen = 1'b1;
                  res = RES_EMPTY;
                end
              end else begin
                res.point_valid = 1'b1;
                res.point_x = 7'(nx);
                res.point_y = 7'(ny);
                res.trace_done = 1'b0;
              end
            end
          end
        end
        if (res.trace_done) trace_idle = 1'b1;
      end
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [6:0] want_v,
                             input logic [6:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      error_count++;
    end
  endtask

  // Request driver: offers the next pending transaction at the falling edge.
  always @(negedge clk) begin : drive_requests
    logic nxt_valid;
    mct_req_t nxt_data;
    nxt_valid = req_valid && !req_fire;
    nxt_data = req_data;
    if (!rst && !nxt_valid && pending_reqs.size() > 0 &&
        (quiet_mode || $urandom_range(99) >= IDLE_PCT)) begin
      nxt_data = pending_reqs.pop_front();
      nxt_valid = 1'b1;
    end
    req_valid <= nxt_valid;
    req_data <= nxt_data;
  end

  // Result receiver: random stalls plus one long hold-off.
  always @(negedge clk) begin : drive_result_stall
    if (burst_served != burst_requests) begin
      burst_served = burst_requests;
      burst_left = HOLD_OFF_CYCLES;
    end
    if (burst_left > 0) begin
      burst_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= !quiet_mode && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Monitor: predicts on each accepted request and checks each accepted result.
  always @(posedge clk) begin : watch_channels
    mct_res_t want;
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_valid && !req_stall;
      if (req_valid && !req_stall) begin
        expected_points = {expected_points, next_contour_result(req_data)};
        n_accepted++;
      end
      if (res_valid && !res_stall) begin
        if (expected_points.size() == 0) begin
          $display("%0t: result with nothing pending, expected none, actual %p",
                   $time, res_data);
          error_count++;
        end else begin
          want = expected_points.pop_front();
          check_field("point_valid", 7'(want.point_valid), 7'(res_data.point_valid));
          check_field("point_x", want.point_x, res_data.point_x);
          check_field("point_y", want.point_y, res_data.point_y);
          check_field("trace_done", 7'(want.trace_done), 7'(res_data.trace_done));
          if (want.point_valid) n_points++;
          if (want.trace_done) n_ends++;
        end
      end
      if (cfg_write) begin
        if (cfg_index == REG_GRID_WIDTH) grid_w_cfg = cfg_data;
        else grid_h_cfg = cfg_data;
      end
    end
  end

  task automatic add_req(input logic [1:0] kind, input int x, input int y);
    mct_req_t rq;
    rq.req_type = kind;
    rq.cell_x = 7'(x);
    rq.cell_y = 7'(y);
    pending_reqs = {pending_reqs, rq};
    n_queued++;
  endtask

  task automatic add_steps(input int n);
    for (int i = 0; i < n; i++) add_req(REQ_STEP, $urandom, $urandom);
  endtask

  // Waits until every queued transaction is taken and every result has come.
  task automatic wait_idle();
    @(negedge clk);
    while (n_accepted != n_queued || expected_points.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  // Random traffic: mostly blobs followed by a start and a run of steps.
  task automatic random_phase(input int n_items, input int lead_steps,
                              input logic calm, input logic hold_off);
    int w, h, made, span, ox, oy, n_steps;
    @(posedge clk);
    quiet_mode = calm;
    w = side_of(grid_w_cfg);
    h = side_of(grid_h_cfg);
    add_steps(lead_steps);
    made = lead_steps;
    while (made < n_items) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(99) < 70) begin
          add_req(REQ_CLEAR, $urandom, $urandom);
          made++;
        end
        span = $urandom_range(2, 6);
        ox = $urandom_range(0, (w > span) ? w - span : 0);
        oy = $urandom_range(0, (h > span) ? h - span : 0);
        for (int j = 0; j < span; j++) begin
          for (int i = 0; i < span; i++) begin
            if ($urandom_range(99) < 65) begin
              add_req(REQ_MARK, ox + i, oy + j);
              made++;
            end
          end
        end
        add_req(REQ_START, $urandom, $urandom);
        n_steps = $urandom_range(4, 5 * span + 6);
        add_steps(n_steps);
        made += n_steps + 1;
      end else begin
        add_req(2'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom_range(0, 127));
        made++;
      end
    end
    if (hold_off) burst_requests++;
  endtask

  initial begin : run_test
    int phase_w [N_PHASES];
    int phase_h [N_PHASES];
    phase_w = '{8, 3, 12, 6, 128, 4, 16, 3, 7, 200, 10, 5, 9, 1};
    phase_h = '{8, 3, 5, 20, 128, 4, 6, 128, 7, 255, 2, 5, 9, 9};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Full-size grid: no trace, empty grid, isolated corner, 2x2 at the far corner.
    @(posedge clk);
    add_req(REQ_STEP, 127, 127);
    add_req(REQ_START, 0, 0);
    add_req(REQ_MARK, 0, 0);
    add_req(REQ_START, 127, 127);
    add_req(REQ_STEP, 0, 0);
    add_req(REQ_STEP, 0, 0);
    add_req(REQ_CLEAR, 127, 127);
    add_req(REQ_MARK, 126, 126);
    add_req(REQ_MARK, 127, 126);
    add_req(REQ_MARK, 126, 127);
    add_req(REQ_MARK, 127, 127);
    add_req(REQ_START, 0, 0);
    add_steps(9);
    add_req(REQ_MARK, 0, 0);
    add_req(REQ_START, 0, 0);
    add_req(REQ_CLEAR, 0, 0);
    add_req(REQ_STEP, 0, 0);
    wait_idle();

    // Small grid with marks beyond it; the start cell then falls off the grid
    // and the trace circles the remaining block until the step cap ends it.
    write_reg(REG_GRID_WIDTH, 8'd5);
    write_reg(REG_GRID_HEIGHT, 8'd3);
    @(posedge clk);
    add_req(REQ_MARK, 5, 0);
    add_req(REQ_MARK, 0, 3);
    add_req(REQ_MARK, 127, 127);
    add_req(REQ_MARK, 3, 0);
    add_req(REQ_MARK, 1, 1);
    add_req(REQ_MARK, 2, 1);
    add_req(REQ_MARK, 1, 2);
    add_req(REQ_MARK, 2, 2);
    add_req(REQ_START, 0, 0);
    wait_idle();
    write_reg(REG_GRID_WIDTH, MIN_SIDE);
    @(posedge clk);
    add_steps(76);
    wait_idle();

    // Sizes below the minimum and above the coordinate range.
    write_reg(REG_GRID_WIDTH, 8'd2);
    @(posedge clk);
    add_req(REQ_START, 0, 0);
    add_req(REQ_STEP, 0, 0);
    wait_idle();
    write_reg(REG_GRID_WIDTH, 8'd255);
    write_reg(REG_GRID_HEIGHT, 8'd0);
    @(posedge clk);
    add_req(REQ_MARK, 10, 10);
    add_req(REQ_START, 0, 0);
    add_req(REQ_STEP, 0, 0);
    wait_idle();
    write_reg(REG_GRID_HEIGHT, 8'd255);
    @(posedge clk);
    add_req(REQ_START, 0, 0);
    add_steps(3);
    wait_idle();

    // Random phases; odd ones resize the grid halfway while a trace may be active.
    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(REG_GRID_WIDTH, 8'(phase_w[p]));
      write_reg(REG_GRID_HEIGHT, 8'(phase_h[p]));
      if (p % 2 == 1) begin
        random_phase(40, 0, 1'b0, p == 1);
        wait_idle();
        write_reg(REG_GRID_HEIGHT, 8'($urandom_range(3, 16)));
        random_phase(40, 6, 1'b0, 1'b0);
      end else begin
        random_phase(80, 0, p == 2, 1'b0);
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Ran %0d requests over %0d register writes, grids from 0 to 255 per side.",
             n_accepted, n_settings);
    $display("Checked %0d contour points and %0d trace endings.", n_points, n_ends);
    if (error_count == 0) begin
      $display("** moore_contour_tracer: PASSED **");
    end else begin
      $display("** moore_contour_tracer: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(20_000_000);
    $display("%0t: timeout with %0d results outstanding", $time, expected_points.size());
    $display("** moore_contour_tracer: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/mct_pkg.sv
design/moore_contour_tracer.sv
dv/tb_moore_contour_tracer.sv
